// ----- rtl/bresenham_line_generator_top_macros.svh -----
// Assertion macros used by the line generator checker.
`ifndef BRESENHAM_LINE_GENERATOR_TOP_MACROS_SVH
`define BRESENHAM_LINE_GENERATOR_TOP_MACROS_SVH

// Implication into the next cycle, disabled while in reset.
`define BLG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Same-cycle implication, disabled while in reset.
`define BLG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define BLG_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/blg_pkg.sv -----
// Shared constants and types of the line generator.
package blg_pkg;

    localparam int MAX_DIM  = 4096;
    localparam int COORD_W  = $clog2(MAX_DIM);   // pixel coordinate width
    localparam int DIM_W    = COORD_W + 1;       // holds MAX_DIM itself
    localparam int ERR_W    = COORD_W + 3;       // signed error term
    localparam int IN_W     = 16;                // endpoint field width
    localparam int CFG_W    = 13;                // canvas register width
    localparam int CFG_IDX_W = 8;
    localparam int COLOR_W  = 24;
    localparam int S_DATA_W = 4 * IN_W + COLOR_W;        // 88 bits, 11 bytes
    localparam int M_DATA_W = 2 * COORD_W + COLOR_W;     // 48 bits, 6 bytes

    typedef enum logic [0:0] {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CANVAS_WIDTH  = 8'd0,
        REG_CANVAS_HEIGHT = 8'd1
    } t_reg_index;

    // Line parameters worked out from a start request.
    typedef struct packed {
        logic                    valid;       // both endpoints on the canvas
        logic                    major_is_x;
        logic [COORD_W-1:0]      x0;
        logic [COORD_W-1:0]      y0;
        logic [COORD_W-1:0]      major_end;
        logic [COORD_W-1:0]      major_delta;
        logic [COORD_W-1:0]      minor_delta;
        logic                    minor_neg;
        logic signed [ERR_W-1:0] error_init;
    } t_line_setup;

endpackage

// ----- rtl/blg_setup.sv -----
// Line setup: canvas clip check, axis choice, endpoint swap, initial error.
module blg_setup (
    input  logic [blg_pkg::IN_W-1:0]  i_start_x,
    input  logic [blg_pkg::IN_W-1:0]  i_start_y,
    input  logic [blg_pkg::IN_W-1:0]  i_end_x,
    input  logic [blg_pkg::IN_W-1:0]  i_end_y,
    input  logic [blg_pkg::CFG_W-1:0] i_canvas_width,
    input  logic [blg_pkg::CFG_W-1:0] i_canvas_height,
    output blg_pkg::t_line_setup      o_setup
);
    import blg_pkg::*;

    localparam logic [CFG_W-1:0] DIM_MAX = CFG_W'(MAX_DIM);

    logic [CFG_W-1:0]   w_eff;
    logic [CFG_W-1:0]   h_eff;
    logic [COORD_W-1:0] x0, y0, x1, y1;
    logic [COORD_W-1:0] adx, ady;
    logic               major_x;
    logic [COORD_W-1:0] major_d, minor_d;

    always_comb begin
        w_eff = (i_canvas_width  > DIM_MAX) ? DIM_MAX : i_canvas_width;
        h_eff = (i_canvas_height > DIM_MAX) ? DIM_MAX : i_canvas_height;

        o_setup.valid = (17'(i_start_x) < 17'(w_eff)) && (17'(i_end_x) < 17'(w_eff)) &&
                        (17'(i_start_y) < 17'(h_eff)) && (17'(i_end_y) < 17'(h_eff));

        // On-canvas coordinates fit the pixel width.
        x0 = i_start_x[COORD_W-1:0];
        y0 = i_start_y[COORD_W-1:0];
        x1 = i_end_x[COORD_W-1:0];
        y1 = i_end_y[COORD_W-1:0];

        adx = (x0 > x1) ? x0 - x1 : x1 - x0;
        ady = (y0 > y1) ? y0 - y1 : y1 - y0;
        major_x = ady < adx;
        major_d = major_x ? adx : ady;
        minor_d = major_x ? ady : adx;

        o_setup.major_is_x  = major_x;
        o_setup.major_delta = major_d;
        o_setup.minor_delta = minor_d;

        if (major_x) begin
            // walk x upward
            if (x0 > x1) begin
                o_setup.x0        = x1;
                o_setup.y0        = y1;
                o_setup.major_end = x0;
                o_setup.minor_neg = y0 < y1;
            end else begin
                o_setup.x0        = x0;
                o_setup.y0        = y0;
                o_setup.major_end = x1;
                o_setup.minor_neg = y1 < y0;
            end
        end else begin
            // walk y upward
            if (y0 > y1) begin
                o_setup.x0        = x1;
                o_setup.y0        = y1;
                o_setup.major_end = y0;
                o_setup.minor_neg = x0 < x1;
            end else begin
                o_setup.x0        = x0;
                o_setup.y0        = y0;
                o_setup.major_end = y1;
                o_setup.minor_neg = x1 < x0;
            end
        end

        o_setup.error_init = $signed({2'b00, minor_d, 1'b0}) - $signed({3'b000, major_d});
    end

endmodule

// ----- rtl/bresenham_line_generator_top.sv -----
// Top level of the Bresenham line generator: request decode, line state, result register.
//
// Bresenham line generator. A start request (tuser opcode OP_START) loads two
// endpoints and a color; if either endpoint lies outside the canvas set by the
// canvas_width / canvas_height registers (values above 4096 act as 4096, zero
// rejects everything) the line is dropped and the block goes idle. Each advance
// request (OP_ADVANCE) then yields the next pixel of the line, walking the major
// axis upward, with tlast on the final pixel; an advance while idle yields
// nothing, and a start during a line replaces it. The line state is updated at
// the accept edge by one compare and add on the state registers, and the pixel
// lands in a single output register. A new request is taken every cycle in which
// that register is empty or being drained, so the sustained rate is one pixel per
// clock; a stall on the master side holds off the slave side in the same cycle.
// Configuration writes are always ready and should be issued only while no line
// is being drawn.
module bresenham_line_generator_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    // Configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [blg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [blg_pkg::CFG_W-1:0]      i_cfg_data,

    // Request stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata, low bit up: start_x[15:0], start_y[31:16], end_x[47:32],
    // end_y[63:48], color[87:64]
    input  logic [blg_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // tuser: opcode[0]
    input  logic [0:0]                     s_axis_tuser,

    // Pixel stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata, low bit up: pixel_x[11:0], pixel_y[23:12], pixel_color[47:24]
    output logic [blg_pkg::M_DATA_W-1:0]   m_axis_tdata,
    output logic                           m_axis_tlast
);
    import blg_pkg::*;

    // Canvas registers
    logic [CFG_W-1:0] r_canvas_width;
    logic [CFG_W-1:0] r_canvas_height;

    // Line state
    logic                    r_active;
    logic                    r_major_is_x;
    logic [COORD_W-1:0]      r_cur_x;
    logic [COORD_W-1:0]      r_cur_y;
    logic [COORD_W-1:0]      r_major_end;
    logic [COORD_W-1:0]      r_major_delta;
    logic [COORD_W-1:0]      r_minor_delta;
    logic                    r_minor_neg;
    logic signed [ERR_W-1:0] r_error;
    logic [COLOR_W-1:0]      r_color;

    // Result register
    logic                    r_out_valid;
    logic [M_DATA_W-1:0]     r_out_data;
    logic                    r_out_last;

    logic [IN_W-1:0]    req_start_x, req_start_y, req_end_x, req_end_y;
    logic [COLOR_W-1:0] req_color;
    t_opcode            req_op;
    logic               req_accept;
    logic               emit;           // accepted advance on an active line
    t_line_setup        setup;

    // next-state of an advance
    logic [COORD_W-1:0]      major_cur;
    logic                    is_last;
    logic                    err_pos;
    logic [COORD_W-1:0]      minor_cur;
    logic [COORD_W-1:0]      n_minor;
    logic [COORD_W-1:0]      n_major;
    logic signed [ERR_W-1:0] n_error;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign req_accept    = s_axis_tvalid && s_axis_tready;
    assign emit          = req_accept && (req_op == OP_ADVANCE) && r_active;

    assign req_start_x = s_axis_tdata[IN_W-1:0];
    assign req_start_y = s_axis_tdata[2*IN_W-1:IN_W];
    assign req_end_x   = s_axis_tdata[3*IN_W-1:2*IN_W];
    assign req_end_y   = s_axis_tdata[4*IN_W-1:3*IN_W];
    assign req_color   = s_axis_tdata[S_DATA_W-1:4*IN_W];
    assign req_op      = t_opcode'(s_axis_tuser[0]);

    blg_setup u_setup (
        .i_start_x       (req_start_x),
        .i_start_y       (req_start_y),
        .i_end_x         (req_end_x),
        .i_end_y         (req_end_y),
        .i_canvas_width  (r_canvas_width),
        .i_canvas_height (r_canvas_height),
        .o_setup         (setup)
    );

    always_comb begin
        major_cur = r_major_is_x ? r_cur_x : r_cur_y;
        minor_cur = r_major_is_x ? r_cur_y : r_cur_x;
        is_last   = major_cur >= r_major_end;
        err_pos   = !r_error[ERR_W-1] && (r_error != '0);
        n_major   = major_cur + COORD_W'(1);
        if (err_pos) begin
            n_minor = r_minor_neg ? minor_cur - COORD_W'(1) : minor_cur + COORD_W'(1);
            n_error = r_error + $signed({2'b00, r_minor_delta, 1'b0})
                              - $signed({2'b00, r_major_delta, 1'b0});
        end else begin
            n_minor = minor_cur;
            n_error = r_error + $signed({2'b00, r_minor_delta, 1'b0});
        end
    end

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_width  <= CFG_W'(800);
            r_canvas_height <= CFG_W'(600);
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_CANVAS_WIDTH) begin
                r_canvas_width <= i_cfg_data;
            end
            if (i_cfg_index == REG_CANVAS_HEIGHT) begin
                r_canvas_height <= i_cfg_data;
            end
        end
    end

    // Line state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= 1'b0;
            r_major_is_x  <= 1'b0;
            r_cur_x       <= '0;
            r_cur_y       <= '0;
            r_major_end   <= '0;
            r_major_delta <= '0;
            r_minor_delta <= '0;
            r_minor_neg   <= 1'b0;
            r_error       <= '0;
            r_color       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            // a new pixel refills the register, otherwise a drain empties it
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (req_accept) begin
                unique case (req_op)
                    OP_START: begin
                        // a rejected line leaves the block idle
                        r_active <= setup.valid;
                        if (setup.valid) begin
                            r_major_is_x  <= setup.major_is_x;
                            r_cur_x       <= setup.x0;
                            r_cur_y       <= setup.y0;
                            r_major_end   <= setup.major_end;
                            r_major_delta <= setup.major_delta;
                            r_minor_delta <= setup.minor_delta;
                            r_minor_neg   <= setup.minor_neg;
                            r_error       <= setup.error_init;
                            r_color       <= req_color;
                        end
                    end
                    OP_ADVANCE: begin
                        if (r_active) begin
                            r_out_data  <= {r_color, r_cur_y, r_cur_x};
                            r_out_last  <= is_last;
                            if (is_last) begin
                                r_active <= 1'b0;
                            end else begin
                                r_error <= n_error;
                                if (r_major_is_x) begin
                                    r_cur_x <= n_major;
                                    r_cur_y <= n_minor;
                                end else begin
                                    r_cur_y <= n_major;
                                    r_cur_x <= n_minor;
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

// ----- rtl/blg_checker.sv -----
// Port-level checker of the line generator and its bind to the top level.
`include "bresenham_line_generator_top_macros.svh"

module blg_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [0:0]                    s_axis_tuser,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [blg_pkg::M_DATA_W-1:0]  m_axis_tdata,
    input  logic                          m_axis_tlast
);
    import blg_pkg::*;

    logic s_acc_start;
    logic out_free;

    assign s_acc_start = s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OP_START);
    assign out_free    = !m_axis_tvalid || m_axis_tready;

    // a stalled pixel holds
    `BLG_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled pixel changed")

    // a start request never yields a pixel
    `BLG_ASSERT_NEXT(a_start_silent, s_acc_start && out_free, !m_axis_tvalid, "pixel after start request")

    // an empty result register never holds off a request
    `BLG_ASSERT_NOW(a_ready_when_empty, !m_axis_tvalid, s_axis_tready, "request stalled with empty output")

    // reset empties the result register
    `BLG_ASSERT_RST(a_reset_empty, !i_rst_n, !m_axis_tvalid, "pixel valid after reset")

endmodule

bind bresenham_line_generator_top blg_checker u_blg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
